>>> hdl/ffac_pkg.sv
// ----------------------------------------------------------------------------
// ffac_pkg
// Shared widths, status codes and the command and status bundles between the
// allocator controller and its datapath.
// ----------------------------------------------------------------------------
package ffac_pkg;

  localparam int ADDR_BITS  = 16;
  localparam int SIZE_BITS  = ADDR_BITS + 1;
  localparam int MAX_ALLOCS = 32;
  localparam int NREG       = MAX_ALLOCS + 1;
  localparam int IDX_BITS   = $clog2(NREG + 1);
  localparam int SLOT_BITS  = $clog2(MAX_ALLOCS);

  localparam logic [SIZE_BITS-1:0] POOL_LIMIT = SIZE_BITS'(1) << ADDR_BITS;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // free-list write operations
  localparam logic [2:0] FW_TRIM  = 3'd0;
  localparam logic [2:0] FW_SHDN  = 3'd1;
  localparam logic [2:0] FW_SHUP  = 3'd2;
  localparam logic [2:0] FW_MBOTH = 3'd3;
  localparam logic [2:0] FW_MPREV = 3'd4;
  localparam logic [2:0] FW_MNEXT = 3'd5;
  localparam logic [2:0] FW_INS   = 3'd6;
  localparam logic [2:0] FW_INIT  = 3'd7;

  // free-list read address selects
  localparam logic [1:0] FR_CUR  = 2'd0;
  localparam logic [1:0] FR_NEXT = 2'd1;
  localparam logic [1:0] FR_SLOT = 2'd2;

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [SIZE_BITS-1:0] size;
  } region_t;

  typedef struct packed {
    logic       take;
    logic       fr_en;
    logic [1:0] fr_sel;
    logic       fw_en;
    logic [2:0] fw_op;
    logic       ar_en;
    logic       aw_en;
    logic       a_clr;
    logic       idx_inc;
    logic       slot_inc;
    logic       slot_dec;
    logic       slot_cnt;
    logic       keep_s;
    logic       keep_prev;
    logic       keep_next;
    logic       keep_alloc;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       res_ld;
    logic [1:0] res_st;
    logic       res_grant;
    logic       emit;
  } ffac_cmd_t;

  typedef struct packed {
    logic is_free;
    logic req_zero;
    logic idx_end;
    logic idx_last;
    logic slot_end;
    logic slot_free;
    logic slot_at_idx;
    logic fit;
    logic exact;
    logic amatch;
    logic after;
    logic join_prev;
    logic join_next;
    logic list_full;
    logic out_free;
  } ffac_stat_t;

endpackage

>>> hdl/first_fit_allocator_coalescing_unit.sv
// Sequence: an allocate scans the free regions for the first that fits, then the
//   table for a free slot, and shifts later regions down when it takes a region
//   whole. A free searches the table, scans the regions for the insert point and
//   shifts later regions up on insert or down after a two-sided merge.
// Throughput: one transaction at a time; the next is taken only once the result is handed on.
// Reset: the initial region is written first, then the unit takes requests.
// ----------------------------------------------------------------------------
// first_fit_allocator_coalescing_unit
// First-fit byte pool allocator with address-ordered, coalescing free list.
// ----------------------------------------------------------------------------
module first_fit_allocator_coalescing_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffac_pkg::SIZE_BITS-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cmd,
  input  logic [ffac_pkg::SIZE_BITS-1:0] request_size,
  input  logic [ffac_pkg::ADDR_BITS-1:0] address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ffac_pkg::ADDR_BITS-1:0] granted_address,
  output logic [1:0]                     status
);

  ffac_pkg::ffac_cmd_t  dcmd;
  ffac_pkg::ffac_stat_t dstat;

  ffac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dstat),
    .cmd      (dcmd)
  );

  ffac_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd_in          (cmd),
    .request_size    (request_size),
    .address         (address),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .granted_address (granted_address),
    .status          (status),
    .cmd             (dcmd),
    .stat            (dstat)
  );

endmodule

>>> hdl/ffac_ctrl.sv
// ----------------------------------------------------------------------------
// ffac_ctrl
// Sequencer for allocate and free transactions: scans, table search, list
// shifts and result hand-off, driving the datapath by command bundle.
// ----------------------------------------------------------------------------
module ffac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ffac_pkg::ffac_stat_t stat,
  output ffac_pkg::ffac_cmd_t  cmd
);

  localparam logic [4:0] S_INIT    = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_DISP    = 5'd2;
  localparam logic [4:0] S_A_FCHK  = 5'd3;
  localparam logic [4:0] S_A_FNEXT = 5'd4;
  localparam logic [4:0] S_A_SLOT  = 5'd5;
  localparam logic [4:0] S_R_RD    = 5'd6;
  localparam logic [4:0] S_R_WR    = 5'd7;
  localparam logic [4:0] S_F_AWAIT = 5'd8;
  localparam logic [4:0] S_F_ANEXT = 5'd9;
  localparam logic [4:0] S_F_POS   = 5'd10;
  localparam logic [4:0] S_F_PCHK  = 5'd11;
  localparam logic [4:0] S_F_DEC   = 5'd12;
  localparam logic [4:0] S_U_CHK   = 5'd13;
  localparam logic [4:0] S_U_WR    = 5'd14;
  localparam logic [4:0] S_EMIT    = 5'd15;

  logic [4:0] state;
  logic [4:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_INIT: begin
        cmd.fw_en  = 1'b1;
        cmd.fw_op  = ffac_pkg::FW_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.is_free) begin
          cmd.ar_en  = 1'b1;
          state_next = S_F_AWAIT;
        end else if (stat.req_zero || stat.idx_end) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_NOFIT;
          state_next = S_EMIT;
        end else begin
          cmd.fr_en  = 1'b1;
          cmd.fr_sel = ffac_pkg::FR_CUR;
          state_next = S_A_FCHK;
        end
      end
      S_A_FCHK: begin
        if (stat.fit) begin
          cmd.keep_s = 1'b1;
          state_next = S_A_SLOT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_A_FNEXT;
        end
      end
      S_A_FNEXT: begin
        if (stat.idx_end) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_NOFIT;
          state_next = S_EMIT;
        end else begin
          cmd.fr_en  = 1'b1;
          cmd.fr_sel = ffac_pkg::FR_CUR;
          state_next = S_A_FCHK;
        end
      end
      S_A_SLOT: begin
        if (stat.slot_end) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_FULL;
          state_next = S_EMIT;
        end else if (stat.slot_free) begin
          cmd.aw_en     = 1'b1;
          cmd.res_ld    = 1'b1;
          cmd.res_st    = ffac_pkg::ST_OK;
          cmd.res_grant = 1'b1;
          if (stat.exact) begin
            state_next = S_R_RD;
          end else begin
            cmd.fw_en  = 1'b1;
            cmd.fw_op  = ffac_pkg::FW_TRIM;
            state_next = S_EMIT;
          end
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_R_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.fr_en  = 1'b1;
          cmd.fr_sel = ffac_pkg::FR_NEXT;
          state_next = S_R_WR;
        end
      end
      S_R_WR: begin
        cmd.fw_en   = 1'b1;
        cmd.fw_op   = ffac_pkg::FW_SHDN;
        cmd.idx_inc = 1'b1;
        state_next  = S_R_RD;
      end
      S_F_AWAIT: begin
        if (stat.amatch) begin
          cmd.keep_alloc = 1'b1;
          state_next     = S_F_POS;
        end else begin
          cmd.slot_inc = 1'b1;
          state_next   = S_F_ANEXT;
        end
      end
      S_F_ANEXT: begin
        if (stat.slot_end) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_UNKNOWN;
          state_next = S_EMIT;
        end else begin
          cmd.ar_en  = 1'b1;
          state_next = S_F_AWAIT;
        end
      end
      S_F_POS: begin
        if (stat.idx_end) begin
          state_next = S_F_DEC;
        end else begin
          cmd.fr_en  = 1'b1;
          cmd.fr_sel = ffac_pkg::FR_CUR;
          state_next = S_F_PCHK;
        end
      end
      S_F_PCHK: begin
        if (stat.after) begin
          cmd.keep_next = 1'b1;
          state_next    = S_F_DEC;
        end else begin
          cmd.keep_prev = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = S_F_POS;
        end
      end
      S_F_DEC: begin
        if (!stat.join_prev && !stat.join_next && stat.list_full) begin
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_FULL;
          state_next = S_EMIT;
        end else begin
          cmd.a_clr  = 1'b1;
          cmd.res_ld = 1'b1;
          cmd.res_st = ffac_pkg::ST_OK;
          if (stat.join_prev && stat.join_next) begin
            cmd.fw_en  = 1'b1;
            cmd.fw_op  = ffac_pkg::FW_MBOTH;
            state_next = S_R_RD;
          end else if (stat.join_prev) begin
            cmd.fw_en  = 1'b1;
            cmd.fw_op  = ffac_pkg::FW_MPREV;
            state_next = S_EMIT;
          end else if (stat.join_next) begin
            cmd.fw_en  = 1'b1;
            cmd.fw_op  = ffac_pkg::FW_MNEXT;
            state_next = S_EMIT;
          end else begin
            cmd.slot_cnt = 1'b1;
            state_next   = S_U_CHK;
          end
        end
      end
      S_U_CHK: begin
        if (stat.slot_at_idx) begin
          cmd.fw_en   = 1'b1;
          cmd.fw_op   = ffac_pkg::FW_INS;
          cmd.cnt_inc = 1'b1;
          state_next  = S_EMIT;
        end else begin
          cmd.fr_en  = 1'b1;
          cmd.fr_sel = ffac_pkg::FR_SLOT;
          state_next = S_U_WR;
        end
      end
      S_U_WR: begin
        cmd.fw_en    = 1'b1;
        cmd.fw_op    = ffac_pkg::FW_SHUP;
        cmd.slot_dec = 1'b1;
        state_next   = S_U_CHK;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ffac_dp.sv
// ----------------------------------------------------------------------------
// ffac_dp
// Datapath: free-region memory, allocation table memory with valid bits,
// index counters, operand registers and the result register.
// ----------------------------------------------------------------------------
module ffac_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ffac_pkg::SIZE_BITS-1:0]    cfg_wdata,
  input  logic                              cmd_in,
  input  logic [ffac_pkg::SIZE_BITS-1:0]    request_size,
  input  logic [ffac_pkg::ADDR_BITS-1:0]    address,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ffac_pkg::ADDR_BITS-1:0]    granted_address,
  output logic [1:0]                        status,
  input  ffac_pkg::ffac_cmd_t               cmd,
  output ffac_pkg::ffac_stat_t              stat
);

  localparam int IW = ffac_pkg::IDX_BITS;
  localparam int AW = ffac_pkg::ADDR_BITS;
  localparam int ZW = ffac_pkg::SIZE_BITS;

  ffac_pkg::region_t fmem [ffac_pkg::NREG];
  ffac_pkg::region_t amem [ffac_pkg::MAX_ALLOCS];
  logic [ffac_pkg::MAX_ALLOCS-1:0] valid;

  ffac_pkg::region_t rd;
  ffac_pkg::region_t ard;
  logic [IW-1:0] idx;
  logic [IW-1:0] slot;
  logic [IW-1:0] count;
  logic [ZW-1:0] pool;
  logic          op;
  logic [AW-1:0] addr;
  logic [AW-1:0] s;
  logic [ZW-1:0] z;
  logic [AW-1:0] pst;
  logic [ZW-1:0] psz;
  logic [AW-1:0] nst;
  logic [ZW-1:0] nsz;
  logic [1:0]    pend_st;
  logic [AW-1:0] pend_grant;

  logic [ZW-1:0]                cfg_sat;
  logic [IW-1:0]                fr_addr;
  logic [IW-1:0]                fw_addr;
  ffac_pkg::region_t            fw_data;
  logic                         fw_go;
  logic [ffac_pkg::SLOT_BITS-1:0] aslot;

  assign aslot   = slot[ffac_pkg::SLOT_BITS-1:0];
  assign cfg_sat = (cfg_wdata > ffac_pkg::POOL_LIMIT) ? ffac_pkg::POOL_LIMIT : cfg_wdata;

  always_comb begin
    case (cmd.fr_sel)
      ffac_pkg::FR_NEXT: fr_addr = idx + IW'(1);
      ffac_pkg::FR_SLOT: fr_addr = slot - IW'(1);
      default:           fr_addr = idx;
    endcase
  end

  always_comb begin
    fw_go   = cmd.fw_en || cfg_we;
    fw_addr = idx;
    fw_data = rd;
    if (cfg_we) begin
      fw_addr = '0;
      fw_data = '{start: '0, size: cfg_sat};
    end else begin
      case (cmd.fw_op)
        ffac_pkg::FW_TRIM: begin
          fw_data = '{start: rd.start + z[AW-1:0], size: rd.size - z};
        end
        ffac_pkg::FW_SHDN: begin
          fw_data = rd;
        end
        ffac_pkg::FW_SHUP: begin
          fw_addr = slot;
          fw_data = rd;
        end
        ffac_pkg::FW_MBOTH: begin
          fw_addr = idx - IW'(1);
          fw_data = '{start: pst, size: psz + z + nsz};
        end
        ffac_pkg::FW_MPREV: begin
          fw_addr = idx - IW'(1);
          fw_data = '{start: pst, size: psz + z};
        end
        ffac_pkg::FW_MNEXT: begin
          fw_data = '{start: s, size: nsz + z};
        end
        ffac_pkg::FW_INS: begin
          fw_data = '{start: s, size: z};
        end
        default: begin
          fw_addr = '0;
          fw_data = '{start: '0, size: pool};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fw_go) begin
      fmem[fw_addr] <= fw_data;
    end
    if (cmd.fr_en) begin
      rd <= fmem[fr_addr];
    end
    if (cmd.aw_en) begin
      amem[aslot] <= '{start: s, size: z};
    end
    if (cmd.ar_en) begin
      ard <= amem[aslot];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op   <= cmd_in;
      z    <= request_size;
      addr <= address;
    end else if (cmd.keep_alloc) begin
      s <= ard.start;
      z <= ard.size;
    end else if (cmd.keep_s) begin
      s <= rd.start;
    end
    if (cmd.keep_prev) begin
      pst <= rd.start;
      psz <= rd.size;
    end
    if (cmd.keep_next) begin
      nst <= rd.start;
      nsz <= rd.size;
    end
    if (cmd.res_ld) begin
      pend_st    <= cmd.res_st;
      pend_grant <= cmd.res_grant ? s : '0;
    end
    if (cmd.emit) begin
      status          <= pend_st;
      granted_address <= pend_grant;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      slot      <= '0;
      count     <= IW'(1);
      pool      <= ffac_pkg::POOL_LIMIT;
      valid     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.take) begin
        idx  <= '0;
        slot <= '0;
      end else begin
        if (cmd.idx_inc) begin
          idx <= idx + IW'(1);
        end
        if (cmd.slot_inc) begin
          slot <= slot + IW'(1);
        end else if (cmd.slot_dec) begin
          slot <= slot - IW'(1);
        end else if (cmd.slot_cnt) begin
          slot <= count;
        end
      end
      if (cfg_we) begin
        pool  <= cfg_sat;
        count <= (cfg_sat != '0) ? IW'(1) : '0;
        valid <= '0;
      end else begin
        if (cmd.cnt_inc) begin
          count <= count + IW'(1);
        end else if (cmd.cnt_dec) begin
          count <= count - IW'(1);
        end
        if (cmd.aw_en) begin
          valid[aslot] <= 1'b1;
        end else if (cmd.a_clr) begin
          valid[aslot] <= 1'b0;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    stat.is_free     = (op == ffac_pkg::CMD_FREE);
    stat.req_zero    = (z == '0);
    stat.idx_end     = (idx >= count);
    stat.idx_last    = ({1'b0, idx} + (IW + 1)'(1)) >= {1'b0, count};
    stat.slot_end    = (slot == IW'(ffac_pkg::MAX_ALLOCS));
    stat.slot_free   = !valid[aslot];
    stat.slot_at_idx = (slot == idx);
    stat.fit         = (rd.size >= z);
    stat.exact       = (rd.size == z);
    stat.amatch      = valid[aslot] && (ard.start == addr);
    stat.after       = (rd.start > s);
    stat.join_prev   = (idx != '0) && (({1'b0, pst} + psz) == {1'b0, s});
    stat.join_next   = (idx < count) && (({1'b0, s} + z) == {1'b0, nst});
    stat.list_full   = (count >= IW'(ffac_pkg::NREG));
    stat.out_free    = !out_valid || !out_stall;
  end

endmodule

>>> bench/ffac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffac_checker
// Watches the request and result channels of the first-fit allocator, keeps
// its own free list and allocation table, predicts each result and compares.
// ----------------------------------------------------------------------------
module ffac_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ffac_pkg::SIZE_BITS-1:0] cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           cmd,
  input  logic [ffac_pkg::SIZE_BITS-1:0] request_size,
  input  logic [ffac_pkg::ADDR_BITS-1:0] address,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [ffac_pkg::ADDR_BITS-1:0] granted_address,
  input  logic [1:0]                     status,
  output int                             fail_count,
  output int                             pending
);

  typedef struct packed {
    logic [ffac_pkg::ADDR_BITS-1:0] grant;
    logic [1:0]                     st;
  } outcome_t;

  logic [ffac_pkg::SIZE_BITS-1:0] pool;
  logic [ffac_pkg::SIZE_BITS-1:0] fr_start [ffac_pkg::NREG+1];
  logic [ffac_pkg::SIZE_BITS-1:0] fr_size [ffac_pkg::NREG+1];
  int                             fr_count;
  logic [ffac_pkg::ADDR_BITS-1:0] tbl_start [ffac_pkg::MAX_ALLOCS];
  logic [ffac_pkg::SIZE_BITS-1:0] tbl_size [ffac_pkg::MAX_ALLOCS];
  logic                           tbl_live [ffac_pkg::MAX_ALLOCS];
  outcome_t                       awaited [$];

  function automatic void pool_init(logic [ffac_pkg::SIZE_BITS-1:0] v);
    pool = (v > ffac_pkg::POOL_LIMIT) ? ffac_pkg::POOL_LIMIT : v;
    for (int i = 0; i < ffac_pkg::MAX_ALLOCS; i++) tbl_live[i] = 1'b0;
    fr_count = (pool == 0) ? 0 : 1;
    fr_start[0] = '0;
    fr_size[0] = pool;
  endfunction

  function automatic void drop_region(int i);
    for (int k = i; k + 1 < fr_count; k++) begin
      fr_start[k] = fr_start[k+1];
      fr_size[k] = fr_size[k+1];
    end
    fr_count--;
  endfunction

  function automatic outcome_t place(logic [ffac_pkg::SIZE_BITS-1:0] req);
    outcome_t r;
    int i;
    int slot;
    r = '{grant: '0, st: ffac_pkg::ST_NOFIT};
    if (req == 0) return r;
    for (i = 0; i < fr_count; i++) if (fr_size[i] >= req) break;
    if (i >= fr_count) return r;
    for (slot = 0; slot < ffac_pkg::MAX_ALLOCS; slot++) if (!tbl_live[slot]) break;
    if (slot >= ffac_pkg::MAX_ALLOCS) begin
      r.st = ffac_pkg::ST_FULL;
      return r;
    end
    r.grant = fr_start[i][ffac_pkg::ADDR_BITS-1:0];
    r.st = ffac_pkg::ST_OK;
    tbl_start[slot] = fr_start[i][ffac_pkg::ADDR_BITS-1:0];
    tbl_size[slot] = req;
    tbl_live[slot] = 1'b1;
    if (fr_size[i] > req) begin
      fr_start[i] += req;
      fr_size[i] -= req;
    end else begin
      drop_region(i);
    end
    return r;
  endfunction

  function automatic outcome_t release_block(logic [ffac_pkg::ADDR_BITS-1:0] a);
    outcome_t r;
    int slot;
    int pos;
    logic [ffac_pkg::SIZE_BITS-1:0] s;
    logic [ffac_pkg::SIZE_BITS-1:0] z;
    logic jp;
    logic jn;
    r = '{grant: '0, st: ffac_pkg::ST_UNKNOWN};
    for (slot = 0; slot < ffac_pkg::MAX_ALLOCS; slot++)
      if (tbl_live[slot] && tbl_start[slot] == a) break;
    if (slot >= ffac_pkg::MAX_ALLOCS) return r;
    s = {1'b0, tbl_start[slot]};
    z = tbl_size[slot];
    for (pos = 0; pos < fr_count; pos++) if (fr_start[pos] > s) break;
    jp = pos > 0 && fr_start[pos-1] + fr_size[pos-1] == s;
    jn = pos < fr_count && s + z == fr_start[pos];
    if (!jp && !jn && fr_count >= ffac_pkg::NREG) begin
      r.st = ffac_pkg::ST_FULL;
      return r;
    end
    r.st = ffac_pkg::ST_OK;
    tbl_live[slot] = 1'b0;
    if (jp && jn) begin
      fr_size[pos-1] += z + fr_size[pos];
      drop_region(pos);
    end else if (jp) begin
      fr_size[pos-1] += z;
    end else if (jn) begin
      fr_start[pos] = s;
      fr_size[pos] += z;
    end else begin
      for (int k = fr_count; k > pos; k--) begin
        fr_start[k] = fr_start[k-1];
        fr_size[k] = fr_size[k-1];
      end
      fr_start[pos] = s;
      fr_size[pos] = z;
      fr_count++;
    end
    return r;
  endfunction

  assign pending = awaited.size();

  always @(posedge clk) begin
    outcome_t e;
    if (rst) begin
      pool_init(ffac_pkg::POOL_LIMIT);
      awaited.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) pool_init(cfg_wdata);
      if (in_valid && !in_stall)
        awaited.push_back(cmd == ffac_pkg::CMD_ALLOC ? place(request_size)
                                                     : release_block(address));
      if (out_valid && !out_stall) begin
        if (awaited.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h %0d", granted_address, status);
          fail_count <= fail_count + 1;
        end else begin
          e = awaited.pop_front();
          if (e.grant !== granted_address || e.st !== status) begin
            if (fail_count < 10)
              $display("mismatch: expected grant %h status %0d, got %h %0d",
                       e.grant, e.st, granted_address, status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives allocate and free transactions with random idling, over several pool sizes,
// into the allocator and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [ffac_pkg::SIZE_BITS-1:0] cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic                           cmd;
  logic [ffac_pkg::SIZE_BITS-1:0] request_size;
  logic [ffac_pkg::ADDR_BITS-1:0] address;
  logic                           out_valid;
  logic                           out_stall;
  logic [ffac_pkg::ADDR_BITS-1:0] granted_address;
  logic [1:0]                     status;
  int                             fail_count;
  int                             pending;
  logic                           quiet;
  logic                           hold_off;
  logic [ffac_pkg::ADDR_BITS-1:0] granted [$];

  first_fit_allocator_coalescing_unit dut (.*);

  ffac_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk)
    if (out_valid && !out_stall && status == ffac_pkg::ST_OK && granted_address != 0)
      granted.push_back(granted_address);

  initial begin
    int gap;
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        out_stall <= 1'b0;
        wait (!hold_off);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(logic c, logic [ffac_pkg::SIZE_BITS-1:0] sz,
                      logic [ffac_pkg::ADDR_BITS-1:0] a);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    request_size <= sz;
    address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (3000) @(negedge clk);
  endtask

  task automatic set_pool(logic [ffac_pkg::SIZE_BITS-1:0] v);
    settle();
    granted.delete();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    repeat (4) @(negedge clk);
  endtask

  task automatic random_mix(int n, int maxsz);
    logic [ffac_pkg::ADDR_BITS-1:0] a;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 50) begin
        send(ffac_pkg::CMD_ALLOC, 17'($urandom_range(1, maxsz)), 16'($urandom));
      end else if (k < 85 && granted.size() > 0) begin
        k = $urandom_range(0, granted.size() - 1);
        a = granted[k];
        granted.delete(k);
        send(ffac_pkg::CMD_FREE, 17'($urandom), a);
      end else if (k < 92) begin
        send(ffac_pkg::CMD_FREE, 17'($urandom), (k & 1) ? 16'h0 : 16'($urandom));
      end else begin
        send(ffac_pkg::CMD_ALLOC, (k & 1) ? 17'h0 : 17'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    cmd = ffac_pkg::CMD_ALLOC;
    request_size = '0;
    address = '0;
    quiet = 1'b0;
    hold_off = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    repeat (3) @(negedge clk);

    send(ffac_pkg::CMD_ALLOC, 17'h0, 16'h0);
    send(ffac_pkg::CMD_ALLOC, 17'h1FFFF, 16'hFFFF);
    send(ffac_pkg::CMD_FREE, 17'h0, 16'hFFFF);
    send(ffac_pkg::CMD_ALLOC, 17'h10000, 16'h0);
    send(ffac_pkg::CMD_ALLOC, 17'h1, 16'h0);
    send(ffac_pkg::CMD_FREE, 17'h0, 16'h0);
    for (int i = 0; i < 33; i++) send(ffac_pkg::CMD_ALLOC, 17'd16, 16'h0);
    for (int i = 0; i < 32; i += 2) send(ffac_pkg::CMD_FREE, 17'h0, 16'(i * 16));
    for (int i = 1; i < 32; i += 2) send(ffac_pkg::CMD_FREE, 17'h0, 16'(i * 16));

    set_pool(17'd0);
    send(ffac_pkg::CMD_ALLOC, 17'd1, 16'h0);
    set_pool(17'h1FFFF);
    send(ffac_pkg::CMD_ALLOC, 17'h10000, 16'h0);
    set_pool(17'd1);
    send(ffac_pkg::CMD_ALLOC, 17'd1, 16'h0);
    send(ffac_pkg::CMD_ALLOC, 17'd1, 16'h0);
    set_pool(17'd64);
    for (int i = 0; i < 32; i++) send(ffac_pkg::CMD_ALLOC, 17'd2, 16'h0);
    for (int i = 0; i < 32; i += 2) send(ffac_pkg::CMD_FREE, 17'h0, 16'(i * 2));
    send(ffac_pkg::CMD_ALLOC, 17'd1, 16'h0);

    set_pool(17'd4096);
    hold_off = 1'b1;
    random_mix(40, 300);
    hold_off = 1'b0;
    random_mix(500, 300);
    set_pool(17'd100);
    random_mix(300, 12);
    set_pool(17'h10000);
    random_mix(500, 4000);
    set_pool(17'd700);
    quiet = 1'b1;
    random_mix(400, 40);

    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/ffac_pkg.sv
hdl/ffac_ctrl.sv
hdl/ffac_dp.sv
hdl/first_fit_allocator_coalescing_unit.sv
bench/ffac_checker.sv
bench/tb.sv
